// File: rtl/core/cssc_pkg.sv
// Shared types, constants and a helper function for the current sense sample conditioner.
// Depends on nothing; used by cssc_mul and current_sense_sample_conditioner_top.
`default_nettype none

package cssc_pkg;

    // Input word: a converter sample or a one millisecond tick.
    typedef struct packed {
        logic        mode;
        logic [23:0] sample_code;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] filtered_current_ma;
        logic               reading_valid;
        logic               resync_request;
    } out_word_t;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // 0.2 in Q16 for the moving average step.
    localparam logic signed [MUL_B_W-1:0] ALPHA_NUM = 17'sd13107;

    // Register map (word index = paddr[3:2]).
    localparam int          PADDR_W       = 4;
    localparam logic [1:0]  REG_ZERO_OFS  = 2'd0;
    localparam logic [1:0]  REG_GAIN      = 2'd1;
    localparam logic [1:0]  REG_STUCK_LIM = 2'd2;
    localparam logic [1:0]  REG_MAX_AGE   = 2'd3;

    localparam logic [23:0] ZERO_OFS_RST  = 24'd0;
    localparam logic [31:0] GAIN_RST      = 32'd611345;
    localparam logic [15:0] STUCK_LIM_RST = 16'd1500;
    localparam logic [15:0] MAX_AGE_RST   = 16'd1000;

    localparam logic [15:0] UNCH_MAX = 16'hFFFF;
    localparam logic [16:0] AGE_MAX  = 17'h1FFFF;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL_LO   = 7'b0000010,
        ST_MUL_HI   = 7'b0000100,
        ST_SCALE    = 7'b0001000,
        ST_MUL_STEP = 7'b0010000,
        ST_UPDATE   = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    // Clamp a signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/cssc_mul.sv
// Shared signed multiplier with a registered product for the sample conditioner.
// Depends on cssc_pkg for operand and product widths.
`default_nettype none

module cssc_mul (
    input  wire logic                               clk,
    input  wire logic signed [cssc_pkg::MUL_A_W-1:0] mul_a,
    input  wire logic signed [cssc_pkg::MUL_B_W-1:0] mul_b,
    output logic signed [cssc_pkg::MUL_P_W-1:0]      product
);

    logic signed [cssc_pkg::MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= mul_a * mul_b;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// File: rtl/core/current_sense_sample_conditioner_top.sv
// Top level of the current sense sample conditioner: sequencer, state and APB registers.
// Depends on cssc_pkg and cssc_mul.
`default_nettype none

// Each input word is either a raw 24-bit converter sample or a one millisecond
// tick, and every word gives exactly one result word. A sample is offset
// corrected, scaled by the Q8.24 gain into milliamps with saturation, and fed
// into a 0.8/0.2 exponential moving average; the first sample loads the
// filter directly. All multiplications go through one shared 34x17 signed
// multiplier. A sample passes through ST_MUL_LO, ST_MUL_HI, ST_SCALE,
// ST_MUL_STEP, ST_UPDATE and ST_FINISH (the very first sample skips
// ST_UPDATE, the filter step); a tick goes from ST_IDLE straight to
// ST_FINISH. The result register is loaded as ST_FINISH is left, and the
// next word is taken back in ST_IDLE, one at a time. The block waits in
// its last step only while an earlier result is still held by out_ready low.
// A result also reports validity (filter primed and last sample no older than
// max_age_ms) and a one-shot resync request when the same code has been seen
// for longer than stuck_limit_ms. Registers sit at byte addresses 0, 4, 8 and
// 12: zero offset, gain, stuck limit and maximum age; writes belong to idle
// time.

module current_sense_sample_conditioner_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input words
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire cssc_pkg::in_word_t             in_word,
    // Result words
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output cssc_pkg::out_word_t                 out_word,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cssc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Configuration registers.
    logic [23:0] zero_ofs_reg;
    logic [31:0] gain_reg;
    logic [15:0] stuck_lim_reg;
    logic [15:0] max_age_reg;

    // Sequencer and working registers.
    cssc_pkg::state_t state_reg, state_next;
    logic             mode_reg;
    logic [23:0]      code_reg;
    logic signed [57:0] acc_reg;
    logic signed [31:0] amps_reg;

    // Conditioner state.
    logic [23:0]        prev_code_reg;
    logic               code_seen_reg;
    logic [15:0]        unch_reg;
    logic signed [31:0] filter_reg;
    logic               primed_reg;
    logic [16:0]        age_reg;

    // Result register.
    logic                out_valid_reg;
    cssc_pkg::out_word_t out_word_reg;

    // Shared multiplier.
    logic signed [cssc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cssc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [cssc_pkg::MUL_P_W-1:0] product;

    logic               in_fire;
    logic               cfg_write;
    logic               out_free;
    logic signed [24:0] diff;
    logic signed [32:0] delta;
    logic signed [57:0] scaled_sum;
    logic signed [33:0] scaled_shift;
    logic signed [34:0] step;
    logic signed [35:0] filter_sum;

    // Next values of the watchdog and age state, used at the last step.
    logic        code_new;
    logic        resync;
    logic [15:0] unch_next;
    logic [16:0] age_next;

    cssc_mul u_mul (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    assign in_ready  = (state_reg == cssc_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register reads return the stored value, zero extended.
    always_comb
    begin
        unique case (paddr[3:2])
            cssc_pkg::REG_ZERO_OFS:  prdata = {8'd0, zero_ofs_reg};
            cssc_pkg::REG_GAIN:      prdata = gain_reg;
            cssc_pkg::REG_STUCK_LIM: prdata = {16'd0, stuck_lim_reg};
            cssc_pkg::REG_MAX_AGE:   prdata = {16'd0, max_age_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_ofs_reg  <= cssc_pkg::ZERO_OFS_RST;
            gain_reg      <= cssc_pkg::GAIN_RST;
            stuck_lim_reg <= cssc_pkg::STUCK_LIM_RST;
            max_age_reg   <= cssc_pkg::MAX_AGE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                cssc_pkg::REG_ZERO_OFS:  zero_ofs_reg  <= pwdata[23:0];
                cssc_pkg::REG_GAIN:      gain_reg      <= pwdata;
                cssc_pkg::REG_STUCK_LIM: stuck_lim_reg <= pwdata[15:0];
                cssc_pkg::REG_MAX_AGE:   max_age_reg   <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    // Offset-corrected code, 25 bits signed.
    assign diff = $signed({code_reg[23], code_reg}) - $signed({zero_ofs_reg[23], zero_ofs_reg});

    // Filter error for the moving average step.
    assign delta = $signed({amps_reg[31], amps_reg}) - $signed({filter_reg[31], filter_reg});

    // Operand selection for the shared multiplier. The gain is split into two
    // unsigned 16-bit halves, each zero extended to a positive 17-bit operand.
    always_comb
    begin
        unique case (state_reg)
            cssc_pkg::ST_MUL_LO:
            begin
                mul_a = {{9{diff[24]}}, diff};
                mul_b = $signed({1'b0, gain_reg[15:0]});
            end
            cssc_pkg::ST_MUL_HI:
            begin
                mul_a = {{9{diff[24]}}, diff};
                mul_b = $signed({1'b0, gain_reg[31:16]});
            end
            cssc_pkg::ST_MUL_STEP:
            begin
                mul_a = {delta[32], delta};
                mul_b = cssc_pkg::ALPHA_NUM;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Each partial product fits in 42 bits; the high one is weighted by 2^16.
    assign scaled_sum   = acc_reg + $signed({product[41:0], 16'd0});
    assign scaled_shift = scaled_sum[57:24];

    assign step       = product[50:16];
    assign filter_sum = $signed({{4{filter_reg[31]}}, filter_reg}) + $signed({step[34], step});

    // Stuck watchdog and age counters.
    always_comb
    begin
        code_new  = !code_seen_reg || (code_reg != prev_code_reg);
        resync    = 1'b0;
        unch_next = unch_reg;
        age_next  = age_reg;
        if (mode_reg == cssc_pkg::MODE_TICK)
        begin
            if (unch_reg < cssc_pkg::UNCH_MAX)
            begin
                unch_next = unch_reg + 16'd1;
            end
            if (age_reg < cssc_pkg::AGE_MAX)
            begin
                age_next = age_reg + 17'd1;
            end
        end
        else
        begin
            age_next = 17'd0;
            if (code_new)
            begin
                unch_next = 16'd0;
            end
            else if (unch_reg > stuck_lim_reg)
            begin
                resync    = 1'b1;
                unch_next = 16'd0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cssc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_word.mode == cssc_pkg::MODE_TICK) ?
                                 cssc_pkg::ST_FINISH : cssc_pkg::ST_MUL_LO;
                end
            end
            cssc_pkg::ST_MUL_LO:   state_next = cssc_pkg::ST_MUL_HI;
            cssc_pkg::ST_MUL_HI:   state_next = cssc_pkg::ST_SCALE;
            cssc_pkg::ST_SCALE:    state_next = cssc_pkg::ST_MUL_STEP;
            cssc_pkg::ST_MUL_STEP:
            begin
                state_next = primed_reg ? cssc_pkg::ST_UPDATE : cssc_pkg::ST_FINISH;
            end
            cssc_pkg::ST_UPDATE:   state_next = cssc_pkg::ST_FINISH;
            cssc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cssc_pkg::ST_IDLE;
                end
            end
            default:               state_next = cssc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cssc_pkg::ST_IDLE;
            prev_code_reg <= 24'd0;
            code_seen_reg <= 1'b0;
            unch_reg      <= 16'd0;
            filter_reg    <= 32'sd0;
            primed_reg    <= 1'b0;
            age_reg       <= 17'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A new result may replace one that is taken at the same edge.
            if ((state_reg == cssc_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // The first sample loads the filter; later ones take a 0.2 step.
            if ((state_reg == cssc_pkg::ST_MUL_STEP) && !primed_reg)
            begin
                filter_reg <= amps_reg;
                primed_reg <= 1'b1;
            end
            if (state_reg == cssc_pkg::ST_UPDATE)
            begin
                filter_reg <= cssc_pkg::sat32({{28{filter_sum[35]}}, filter_sum});
            end

            if ((state_reg == cssc_pkg::ST_FINISH) && out_free)
            begin
                unch_reg      <= unch_next;
                age_reg       <= age_next;
                if ((mode_reg == cssc_pkg::MODE_SAMPLE) && code_new)
                begin
                    prev_code_reg <= code_reg;
                    code_seen_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= in_word.mode;
            code_reg <= in_word.sample_code;
        end
        if (state_reg == cssc_pkg::ST_MUL_HI)
        begin
            acc_reg <= {{7{product[50]}}, product};
        end
        if (state_reg == cssc_pkg::ST_SCALE)
        begin
            amps_reg <= cssc_pkg::sat32({{30{scaled_shift[33]}}, scaled_shift});
        end
        if ((state_reg == cssc_pkg::ST_FINISH) && out_free)
        begin
            out_word_reg.filtered_current_ma <= filter_reg;
            out_word_reg.reading_valid       <= primed_reg && ({1'b0, max_age_reg} >= age_next);
            out_word_reg.resync_request      <= resync;
        end
    end

endmodule

`default_nettype wire
